// ===== sv/tfp_pkg.sv =====
package tfp_pkg;

    localparam int ByteW     = 8;
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 8;

    localparam logic [ByteW-1:0] VersionMask = 8'hf8;
    localparam logic [ByteW-1:0] CrcPoly     = 8'h07;
    localparam logic [ByteW-1:0] MaxPayload  = 8'hff;

    localparam logic [4:0] HdrLenShort = 5'd8;
    localparam logic [4:0] HdrLenLong  = 5'd10;

    localparam logic [CfgIndexW-1:0] CFG_SYNC_VALUE  = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_VERSION     = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_INSTANCE_EN = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_ACK_TYPE    = 3'd3;

    localparam logic [ByteW-1:0] SyncReset    = 8'h3c;
    localparam logic [ByteW-1:0] VersionReset = 8'h20;
    localparam logic [ByteW-1:0] AckTypeReset = 8'h22;

    typedef enum logic [2:0] {
        PH_SYNC = 3'd0,
        PH_TYPE = 3'd1,
        PH_LEN  = 3'd2,
        PH_OBJ  = 3'd3,
        PH_INST = 3'd4,
        PH_DATA = 3'd5,
        PH_CRC  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_HEADER  = 3'd1,
        ST_PAYLOAD = 3'd2,
        ST_GOOD    = 3'd3,
        ST_BADCRC  = 3'd4,
        ST_REJECT  = 3'd5
    } status_t;

    typedef struct packed {
        logic [ByteW-1:0] sync_value;
        logic [ByteW-1:0] version_value;
        logic             instance_id_present;
        logic [ByteW-1:0] ack_request_type;
    } cfg_t;

    typedef struct packed {
        status_t          status;
        logic [ByteW-1:0] payload_byte;
        logic [ByteW-1:0] payload_index;
        logic [7:0]       message_type;
        logic [31:0]      object_id;
        logic [15:0]      instance_id;
        logic [15:0]      frame_length;
        logic             ack_request;
    } result_t;

    function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
        logic [ByteW-1:0] v;
        v = crc ^ b;
        for (int i = 0; i < ByteW; i++)
        begin
            if (v[ByteW-1])
            begin
                v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
            end
            else
            begin
                v = {v[ByteW-2:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== sv/tfp_cfg_regs.sv =====
module tfp_cfg_regs
    import tfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_VALUE:  cfg_next.sync_value          = cfg_data;
                CFG_VERSION:     cfg_next.version_value       = cfg_data;
                CFG_INSTANCE_EN: cfg_next.instance_id_present = cfg_data[0];
                CFG_ACK_TYPE:    cfg_next.ack_request_type    = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value          <= SyncReset;
            cfg_reg.version_value       <= VersionReset;
            cfg_reg.instance_id_present <= 1'b0;
            cfg_reg.ack_request_type    <= AckTypeReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/tfp_deframer.sv =====
module tfp_deframer
    import tfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [ByteW-1:0] rx_byte,
    input  cfg_t             cfg,
    output result_t          res
);

    phase_t           phase_reg,    phase_next;
    logic [ByteW-1:0] crc_reg,      crc_next;
    logic [ByteW-1:0] count_reg,    count_next;
    logic [15:0]      length_reg,   length_next;
    logic [7:0]       type_reg,     type_next;
    logic [31:0]      object_reg,   object_next;
    logic [15:0]      instance_reg, instance_next;

    logic [4:0]       hdr_len;
    logic [15:0]      hdr_len_w;
    logic [15:0]      len_new;
    logic [15:0]      plen_raw;
    logic [ByteW-1:0] plen;
    logic [ByteW-1:0] count_inc;
    logic [ByteW-1:0] crc_upd;
    phase_t           after_header;
    logic             version_ok;
    logic             length_bad;

    assign hdr_len    = cfg.instance_id_present ? HdrLenLong : HdrLenShort;
    assign hdr_len_w  = {11'd0, hdr_len};
    assign len_new    = {rx_byte, length_reg[7:0]};
    assign count_inc  = count_reg + 8'd1;
    assign crc_upd    = crc8_step(crc_reg, rx_byte);
    assign version_ok = ((rx_byte & VersionMask) == cfg.version_value);
    assign length_bad = (len_new < hdr_len_w) || (len_new > (hdr_len_w + 16'd255));
    assign after_header = (length_reg <= hdr_len_w) ? PH_CRC : PH_DATA;
    assign plen_raw   = (length_reg > hdr_len_w) ? (length_reg - hdr_len_w) : 16'd0;
    assign plen       = (plen_raw > {8'd0, MaxPayload}) ? MaxPayload : plen_raw[ByteW-1:0];

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        crc_next      = crc_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        type_next     = type_reg;
        object_next   = object_reg;
        instance_next = instance_reg;
        case (phase_reg)
            PH_SYNC:
            begin
                if (rx_byte == cfg.sync_value)
                begin
                    crc_next      = crc8_step(8'd0, rx_byte);
                    type_next     = 8'd0;
                    length_next   = 16'd0;
                    object_next   = 32'd0;
                    instance_next = 16'd0;
                    phase_next    = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (!version_ok)
                begin
                    phase_next = PH_SYNC;
                end
                else
                begin
                    crc_next   = crc_upd;
                    type_next  = rx_byte;
                    count_next = 8'd0;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                crc_next = crc_upd;
                if (count_reg == 8'd0)
                begin
                    length_next = {length_reg[15:8], rx_byte};
                    count_next  = 8'd1;
                end
                else
                begin
                    length_next = len_new;
                    count_next  = 8'd0;
                    phase_next  = length_bad ? PH_SYNC : PH_OBJ;
                end
            end
            PH_OBJ:
            begin
                crc_next   = crc_upd;
                count_next = count_inc;
                case (count_reg[1:0])
                    2'd0:    object_next[7:0]   = object_reg[7:0]   | rx_byte;
                    2'd1:    object_next[15:8]  = object_reg[15:8]  | rx_byte;
                    2'd2:    object_next[23:16] = object_reg[23:16] | rx_byte;
                    default: object_next[31:24] = object_reg[31:24] | rx_byte;
                endcase
                if (count_inc >= 8'd4)
                begin
                    count_next = 8'd0;
                    phase_next = cfg.instance_id_present ? PH_INST : after_header;
                end
            end
            PH_INST:
            begin
                crc_next   = crc_upd;
                count_next = count_inc;
                if (count_reg[0])
                begin
                    instance_next[15:8] = instance_reg[15:8] | rx_byte;
                end
                else
                begin
                    instance_next[7:0] = instance_reg[7:0] | rx_byte;
                end
                if (count_inc >= 8'd2)
                begin
                    count_next = 8'd0;
                    phase_next = after_header;
                end
            end
            PH_DATA:
            begin
                crc_next   = crc_upd;
                count_next = count_inc;
                if (count_inc >= plen)
                begin
                    count_next = 8'd0;
                    phase_next = PH_CRC;
                end
            end
            default:
            begin
                count_next = 8'd0;
                phase_next = PH_SYNC;
            end
        endcase
    end

    // result for this beat
    always_comb
    begin
        res               = '0;
        res.status        = ST_IGNORED;
        res.message_type  = type_next;
        res.object_id     = object_next;
        res.instance_id   = instance_next;
        res.frame_length  = length_next;
        case (phase_reg)
            PH_SYNC:
            begin
                if (rx_byte == cfg.sync_value)
                begin
                    res.status = ST_HEADER;
                end
            end
            PH_TYPE:
            begin
                res.status = version_ok ? ST_HEADER : ST_REJECT;
            end
            PH_LEN:
            begin
                if (count_reg != 8'd0 && length_bad)
                begin
                    res.status = ST_REJECT;
                end
                else
                begin
                    res.status = ST_HEADER;
                end
            end
            PH_OBJ, PH_INST:
            begin
                res.status = ST_HEADER;
            end
            PH_DATA:
            begin
                res.status        = ST_PAYLOAD;
                res.payload_byte  = rx_byte;
                res.payload_index = count_reg;
            end
            default:
            begin
                if (rx_byte == crc_reg)
                begin
                    res.status      = ST_GOOD;
                    res.ack_request = (type_reg == cfg.ack_request_type);
                end
                else
                begin
                    res.status = ST_BADCRC;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC;
            crc_reg      <= 8'd0;
            count_reg    <= 8'd0;
            length_reg   <= 16'd0;
            type_reg     <= 8'd0;
            object_reg   <= 32'd0;
            instance_reg <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            count_reg    <= count_next;
            length_reg   <= length_next;
            type_reg     <= type_next;
            object_reg   <= object_next;
            instance_reg <= instance_next;
        end
    end

endmodule

// ===== sv/telemetry_frame_parser_crc8.sv =====
// channel | signals                     | beat
// --------+-----------------------------+------------------------------------
// in      | in_valid, in_stall, rx_byte | one received byte
// out     | out_valid, out_stall, ...   | one result per byte
// cfg     | cfg_we, cfg_index, cfg_data | one register write
//
// one byte per cycle sustained while out_stall is low; each byte is taken into the input
// register, then parse logic and crc step write its result into the result register
// async active-low reset returns the parser to sync hunting with config registers at defaults
// out_stall holds the result register; the input register still fills, and
// in_stall rises only when both registers hold beats
module telemetry_frame_parser_crc8
    import tfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [7:0]           payload_byte,
    output logic [7:0]           payload_index,
    output logic [7:0]           message_type,
    output logic [31:0]          object_id,
    output logic [15:0]          instance_id,
    output logic [15:0]          frame_length,
    output logic                 ack_request,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    cfg_t             cfg;
    result_t          res;
    result_t          res_reg;
    logic             in_valid_reg, in_valid_next;
    logic [ByteW-1:0] in_byte_reg;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic             in_take;

    tfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tfp_deframer u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign payload_byte  = res_reg.payload_byte;
    assign payload_index = res_reg.payload_index;
    assign message_type  = res_reg.message_type;
    assign object_id     = res_reg.object_id;
    assign instance_id   = res_reg.instance_id;
    assign frame_length  = res_reg.frame_length;
    assign ack_request   = res_reg.ack_request;

endmodule

// ===== sv/tfp_checker.sv =====
module tfp_checker
    import tfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [7:0]  payload_byte,
    input logic [7:0]  payload_index,
    input logic [15:0] frame_length,
    input logic        ack_request
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(payload_byte))
    else $error("stalled result beat changed");

    // acknowledge only on a good frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ack_request |-> status == ST_GOOD)
    else $error("ack request without good frame");

    // payload fields are zero outside payload beats
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_PAYLOAD |-> payload_byte == 8'd0 && payload_index == 8'd0)
    else $error("payload fields set outside payload beat");

    // payload only follows an accepted length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_PAYLOAD |-> frame_length > 16'd8)
    else $error("payload beat with short frame length");

endmodule

bind telemetry_frame_parser_crc8 tfp_checker u_tfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .frame_length  (frame_length),
    .ack_request   (ack_request)
);

// ===== verif/telemetry_frame_parser_crc8_test.sv =====
module telemetry_frame_parser_crc8_test;
    import tfp_pkg::*;

    localparam int QuietLimit = 3000;
    localparam logic [CfgIndexW-1:0] CfgUnused = '1;

    class deframe_tracker;
        cfg_t        cfg;
        phase_t      frame_state;
        logic [7:0]  crc_acc;
        logic [7:0]  byte_pos;
        logic [15:0] len_field;
        logic [7:0]  type_byte;
        logic [31:0] obj_field;
        logic [15:0] inst_field;
        result_t     predicted[$];
        int mismatches;
        int beats_checked;
        int good_frames;
        int ack_frames;
        int crc_errors;
        int rejects;
        int payload_bytes;

        function new();
            cfg.sync_value = SyncReset;
            cfg.version_value = VersionReset;
            cfg.instance_id_present = 1'b0;
            cfg.ack_request_type = AckTypeReset;
            frame_state = PH_SYNC;
            crc_acc = '0;
            byte_pos = '0;
            len_field = '0;
            type_byte = '0;
            obj_field = '0;
            inst_field = '0;
        endfunction

        function logic [7:0] crc_update(logic [7:0] crc, logic [7:0] b);
            logic [7:0] r;
            r = crc ^ b;
            repeat (8)
            begin
                r = r[7] ? ((r << 1) ^ CrcPoly) : (r << 1);
            end
            return r;
        endfunction

        function void write_reg(logic [CfgIndexW-1:0] idx, logic [7:0] data);
            case (idx)
                CFG_SYNC_VALUE:  cfg.sync_value = data;
                CFG_VERSION:     cfg.version_value = data;
                CFG_INSTANCE_EN: cfg.instance_id_present = data[0];
                CFG_ACK_TYPE:    cfg.ack_request_type = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return predicted.size();
        endfunction

        // one received byte in, one predicted result beat out
        function void take_byte(logic [7:0] b);
            result_t r;
            logic [15:0] hl;
            logic [15:0] plen;
            r = '0;
            r.status = ST_IGNORED;
            hl = cfg.instance_id_present ? 16'(HdrLenLong) : 16'(HdrLenShort);
            case (frame_state)
                PH_SYNC:
                begin
                    if (b == cfg.sync_value)
                    begin
                        crc_acc = crc_update(8'h00, b);
                        type_byte = '0;
                        len_field = '0;
                        obj_field = '0;
                        inst_field = '0;
                        frame_state = PH_TYPE;
                        r.status = ST_HEADER;
                    end
                end
                PH_TYPE:
                begin
                    if ((b & VersionMask) != cfg.version_value)
                    begin
                        frame_state = PH_SYNC;
                        r.status = ST_REJECT;
                    end
                    else
                    begin
                        crc_acc = crc_update(crc_acc, b);
                        type_byte = b;
                        byte_pos = '0;
                        frame_state = PH_LEN;
                        r.status = ST_HEADER;
                    end
                end
                PH_LEN:
                begin
                    crc_acc = crc_update(crc_acc, b);
                    r.status = ST_HEADER;
                    if (byte_pos == 8'd0)
                    begin
                        len_field[7:0] = b;
                        byte_pos = 8'd1;
                    end
                    else
                    begin
                        len_field[15:8] = b;
                        byte_pos = 8'd0;
                        if (len_field < hl || len_field > hl + 16'd255)
                        begin
                            frame_state = PH_SYNC;
                            r.status = ST_REJECT;
                        end
                        else
                        begin
                            frame_state = PH_OBJ;
                        end
                    end
                end
                PH_OBJ:
                begin
                    crc_acc = crc_update(crc_acc, b);
                    obj_field = obj_field | (32'(b) << (8 * byte_pos[1:0]));
                    byte_pos++;
                    r.status = ST_HEADER;
                    if (byte_pos >= 8'd4)
                    begin
                        byte_pos = '0;
                        if (cfg.instance_id_present)
                            frame_state = PH_INST;
                        else
                            frame_state = (len_field <= hl) ? PH_CRC : PH_DATA;
                    end
                end
                PH_INST:
                begin
                    crc_acc = crc_update(crc_acc, b);
                    inst_field = inst_field | (16'(b) << (8 * byte_pos[0]));
                    byte_pos++;
                    r.status = ST_HEADER;
                    if (byte_pos >= 8'd2)
                    begin
                        byte_pos = '0;
                        frame_state = (len_field <= hl) ? PH_CRC : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    plen = (len_field > hl) ? len_field - hl : 16'd0;
                    if (plen > 16'd255)
                        plen = 16'd255;
                    crc_acc = crc_update(crc_acc, b);
                    r.status = ST_PAYLOAD;
                    r.payload_byte = b;
                    r.payload_index = byte_pos;
                    byte_pos++;
                    if (16'(byte_pos) >= plen)
                    begin
                        byte_pos = '0;
                        frame_state = PH_CRC;
                    end
                end
                default:
                begin
                    if (b == crc_acc)
                    begin
                        r.status = ST_GOOD;
                        r.ack_request = (type_byte == cfg.ack_request_type);
                    end
                    else
                    begin
                        r.status = ST_BADCRC;
                    end
                    byte_pos = '0;
                    frame_state = PH_SYNC;
                end
            endcase
            r.message_type = type_byte;
            r.object_id = obj_field;
            r.instance_id = inst_field;
            r.frame_length = len_field;
            predicted.push_back(r);
        endfunction

        task flag_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
            if (mismatches < 40)
                $display("mismatch on %s: got %0h, expected %0h (beat %0d)",
                         what, got_v, exp_v, beats_checked);
            mismatches++;
        endtask

        task match_result(result_t got);
            result_t exp;
            if (predicted.size() == 0)
            begin
                flag_mismatch("unexpected result beat, status", got.status, 0);
                return;
            end
            exp = predicted.pop_front();
            if (got.status !== exp.status)
                flag_mismatch("status", got.status, exp.status);
            if (got.payload_byte !== exp.payload_byte)
                flag_mismatch("payload_byte", got.payload_byte, exp.payload_byte);
            if (got.payload_index !== exp.payload_index)
                flag_mismatch("payload_index", got.payload_index, exp.payload_index);
            if (got.message_type !== exp.message_type)
                flag_mismatch("message_type", got.message_type, exp.message_type);
            if (got.object_id !== exp.object_id)
                flag_mismatch("object_id", got.object_id, exp.object_id);
            if (got.instance_id !== exp.instance_id)
                flag_mismatch("instance_id", got.instance_id, exp.instance_id);
            if (got.frame_length !== exp.frame_length)
                flag_mismatch("frame_length", got.frame_length, exp.frame_length);
            if (got.ack_request !== exp.ack_request)
                flag_mismatch("ack_request", got.ack_request, exp.ack_request);
            beats_checked++;
            case (exp.status)
                ST_GOOD:    good_frames++;
                ST_BADCRC:  crc_errors++;
                ST_REJECT:  rejects++;
                ST_PAYLOAD: payload_bytes++;
                default: ;
            endcase
            if (exp.ack_request)
                ack_frames++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           status;
    logic [7:0]           payload_byte;
    logic [7:0]           payload_index;
    logic [7:0]           message_type;
    logic [31:0]          object_id;
    logic [15:0]          instance_id;
    logic [15:0]          frame_length;
    logic                 ack_request;
    logic                 cfg_we = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data = '0;

    deframe_tracker tracker;
    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int bytes_sent = 0;
    int settings_used = 1;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    int hold_left = 0;

    telemetry_frame_parser_crc8 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .payload_byte (payload_byte),
        .payload_index(payload_index),
        .message_type (message_type),
        .object_id    (object_id),
        .instance_id  (instance_id),
        .frame_length (frame_length),
        .ack_request  (ack_request),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: check each taken beat, then pick next cycle's stall
    always @(posedge clk)
    begin : result_side
        result_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.status = status_t'(status);
                got.payload_byte = payload_byte;
                got.payload_index = payload_index;
                got.message_type = message_type;
                got.object_id = object_id;
                got.instance_id = instance_id;
                got.frame_length = frame_length;
                got.ack_request = ack_request;
                tracker.match_result(got);
            end
            if (hold_req && !hold_seen)
                hold_left = 120;
            hold_seen = hold_req;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < take_idle_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("no beat moved for %0d cycles", QuietLimit);
        $display("telemetry_frame_parser_crc8 regression: fail");
        $finish;
    end

    task automatic drive_byte(input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CfgIndexW-1:0] idx, input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [7:0] sync_v, input logic [7:0] ver_v,
                                  input logic [7:0] inst_v, input logic [7:0] ack_v);
        write_register(CFG_SYNC_VALUE, sync_v);
        write_register(CFG_VERSION, ver_v);
        write_register(CFG_INSTANCE_EN, inst_v);
        write_register(CFG_ACK_TYPE, ack_v);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] frame_crc(input logic [7:0] seq[$]);
        logic [7:0] crc;
        crc = 8'h00;
        foreach (seq[i])
            crc = tracker.crc_update(crc, seq[i]);
        return crc;
    endfunction

    task automatic send_frame_bytes(input logic [7:0] seq[$], input bit with_crc,
                                    input logic [7:0] crc_flip);
        if (with_crc)
            seq.push_back(frame_crc(seq) ^ crc_flip);
        foreach (seq[i])
            drive_byte(seq[i]);
    endtask

    // frame sent in two parts with an instance-id change between them
    task automatic send_split(input logic [7:0] seq[$], input int cut, input logic [7:0] inst_v);
        while (tracker.frame_state != PH_SYNC)
            drive_byte(8'($urandom));
        seq.push_back(frame_crc(seq));
        for (int i = 0; i < cut; i++)
            drive_byte(seq[i]);
        drain();
        write_register(CFG_INSTANCE_EN, inst_v);
        cfg_we <= 1'b0;
        for (int i = cut; i < seq.size(); i++)
            drive_byte(seq[i]);
    endtask

    task automatic send_random_frame();
        logic [7:0]  seq[$];
        logic [7:0]  msg;
        logic [15:0] len;
        logic [7:0]  crc_flip;
        int hl;
        int plen;
        int kind;
        int cut;
        kind = $urandom_range(99);
        hl = tracker.cfg.instance_id_present ? 10 : 8;
        if ($urandom_range(29) == 0)
            plen = 255;
        else if ($urandom_range(9) == 0)
            plen = 0;
        else
            plen = $urandom_range(1, 16);
        if ($urandom_range(4) == 0)
            msg = tracker.cfg.ack_request_type;
        else
            msg = tracker.cfg.version_value | 8'($urandom_range(7));
        if (kind < 6)
            msg = tracker.cfg.version_value ^ (8'h08 << $urandom_range(4));
        len = 16'(hl + plen);
        if (kind >= 6 && kind < 12)
        begin
            if ($urandom_range(1) == 0)
                len = 16'($urandom_range(hl - 1));
            else
                len = 16'($urandom_range(hl + 256, 65535));
        end
        seq = {tracker.cfg.sync_value, msg, len[7:0], len[15:8]};
        repeat (hl - 4) seq.push_back(8'($urandom));
        repeat (plen) seq.push_back(8'($urandom));
        crc_flip = (kind >= 12 && kind < 20) ? 8'(1 << $urandom_range(7)) : 8'h00;
        if (kind >= 20 && kind < 28)
        begin
            cut = $urandom_range(1, seq.size());
            while (seq.size() > cut)
                void'(seq.pop_back());
            send_frame_bytes(seq, 1'b0, 8'h00);
        end
        else
        begin
            send_frame_bytes(seq, 1'b1, crc_flip);
        end
    endtask

    task automatic run_frames(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(4) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(3) == 0)
                        drive_byte(tracker.cfg.sync_value);
                    else
                        drive_byte(8'($urandom));
                end
            end
            send_random_frame();
        end
    endtask

    initial
    begin
        logic [7:0] seq[$];
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 37;
        take_idle_pct = 76;
        // ack-type frame, empty payload, all-ones object id
        seq = {8'h3c, 8'h22, 8'h08, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};
        send_frame_bytes(seq, 1'b1, 8'h00);
        // bad version; the rejected byte is not a new sync
        seq = {8'h3c, 8'hff};
        send_frame_bytes(seq, 1'b0, 8'h00);
        // length one below and one above the allowed window
        seq = {8'h3c, 8'h20, 8'h07, 8'h00};
        send_frame_bytes(seq, 1'b0, 8'h00);
        seq = {8'h3c, 8'h27, 8'h08, 8'h01};
        send_frame_bytes(seq, 1'b0, 8'h00);
        // one payload byte, crc broken
        seq = {8'h3c, 8'h21, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame_bytes(seq, 1'b1, 8'hff);
        run_frames(200);
        drain();

        apply_settings(8'h00, 8'h00, 8'h01, 8'h00);
        run_frames(220);
        drain();

        send_idle_pct = 76;
        take_idle_pct = 37;
        apply_settings(8'hff, 8'hf8, 8'h00, 8'hff);
        run_frames(220);
        drain();

        // version with low bits set rejects every frame
        write_register(CfgUnused, 8'hff);
        apply_settings(8'h55, 8'h07, 8'h01, 8'h3f);
        run_frames(60);
        drain();

        send_idle_pct = 0;
        take_idle_pct = 0;
        apply_settings(8'ha5, 8'h48, 8'hff, 8'h4b);
        hold_req <= 1'b1;
        run_frames(220);
        drain();
        hold_req <= 1'b0;

        apply_settings(8'h7e, 8'h20, 8'h00, 8'h21);
        seq = {8'h7e, 8'h20, 8'h0b, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'ha7};
        send_split(seq, 6, 8'h01);
        seq = {8'h7e, 8'h21, 8'h0f, 8'h00, 8'hde, 8'had, 8'hbe, 8'hef, 8'h01, 8'h80,
               8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70};
        send_split(seq, 12, 8'hfe);
        run_frames(200);
        drain();

        $display("%0d result beats checked: %0d good frames (%0d acked), %0d crc errors,",
                 tracker.beats_checked, tracker.good_frames, tracker.ack_frames,
                 tracker.crc_errors);
        $display("%0d header rejects, %0d payload bytes over %0d register settings",
                 tracker.rejects, tracker.payload_bytes, settings_used);
        if (tracker.mismatches == 0)
            $display("telemetry_frame_parser_crc8 regression: pass");
        else
            $display("telemetry_frame_parser_crc8 regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tfp_pkg.sv
sv/tfp_cfg_regs.sv
sv/tfp_deframer.sv
sv/telemetry_frame_parser_crc8.sv
sv/tfp_checker.sv
verif/telemetry_frame_parser_crc8_test.sv
